### sv/mems_pkg.sv
// Package: constants, codes and storage types for the multitrack event merge scheduler.
`default_nettype none
package mems_pkg;

  localparam int MaxTracks  = 16;
  localparam int EventDepth = 4096;

  localparam int TrkW    = $clog2(MaxTracks);
  localparam int TcW     = $clog2(MaxTracks + 1);
  localparam int EvAddrW = $clog2(EventDepth);
  localparam int CntW    = $clog2(EventDepth + 1);
  localparam int DeltaW  = 32;
  localparam int CfgW    = 5;

  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdLoad  = 2'd1;
  localparam logic [1:0] CmdStart = 2'd2;
  localparam logic [1:0] CmdStep  = 2'd3;

  localparam logic [1:0] StAck  = 2'd0;
  localparam logic [1:0] StEmit = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam logic [1:0] StRej  = 2'd3;

  localparam logic [1:0] LenThree = 2'd3;
  localparam logic [1:0] LenTwo   = 2'd2;

  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [1:0]        len;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
  } ev_t;

  // due is the absolute tick (mod 2^32) at which the track's next item is due
  typedef struct packed {
    logic [CntW-1:0]    count;
    logic [EvAddrW-1:0] base;
    logic [CntW-1:0]    pos;
    logic [DeltaW-1:0]  due;
  } tte_t;

endpackage
`default_nettype wire

### sv/multitrack_event_merge_scheduler.sv
// Top level: multitrack event merge scheduler with event store and track table memories.
//
// Usage: one command item enters on the input channel (in_valid_i / in_stall_o) and
// gives exactly one result item on the output channel (out_valid_o / out_stall_i).
// Commands: clear, load event, start playback, play step. track_count is written
// through cfg_we_i / cfg_wdata_i while the block is idle; writes while playing are dropped.
// Items are handled one at a time; in_stall_o is high from acceptance until the result
// has moved into the output register, which may still hold an untaken earlier result.
// Steps per item: clear, and a rejected load or step, go straight to the result; a load
//   writes the event store, then the track table; start reads and rewrites each of the
//   16 track-table entries in turn; play step scans the track table memory, one entry per
//   cycle, then two event store reads and the write-back of the winning track, if any.
// Time is kept as an absolute tick, so only the winning track's entry is rewritten.
// Reset clears all track state and sets track_count to 1; the event store is not
// cleared. While the receiver stalls, the result is held and the next result waits
// in the block, keeping in_stall_o high.
`default_nettype none
module multitrack_event_merge_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mems_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [mems_pkg::TrkW-1:0]     track_i,
  input  wire logic [mems_pkg::DeltaW-1:0]   delta_ticks_i,
  input  wire logic [1:0]                    msg_length_i,
  input  wire logic [7:0]                    in_byte0_i,
  input  wire logic [7:0]                    in_byte1_i,
  input  wire logic [7:0]                    in_byte2_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [mems_pkg::TrkW-1:0]          out_track_o,
  output logic [mems_pkg::DeltaW-1:0]        wait_ticks_o,
  output logic [1:0]                         out_length_o,
  output logic [7:0]                         out_byte0_o,
  output logic [7:0]                         out_byte1_o,
  output logic [7:0]                         out_byte2_o
);
  import mems_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLdWr  = 4'd1;
  localparam logic [3:0] SStEv  = 4'd2;
  localparam logic [3:0] SStWr  = 4'd3;
  localparam logic [3:0] SScan  = 4'd4;
  localparam logic [3:0] SEv0   = 4'd5;
  localparam logic [3:0] SEv1   = 4'd6;
  localparam logic [3:0] SEv2   = 4'd7;
  localparam logic [3:0] SDone  = 4'd8;

  // memories
  ev_t  ev_mem [EventDepth];
  tte_t tt_mem [MaxTracks];

  logic               ev_we;
  logic [EvAddrW-1:0] ev_waddr, ev_raddr;
  ev_t                ev_wdata, ev_rdata_q;
  logic               tt_we;
  logic [TrkW-1:0]    tt_waddr, tt_raddr;
  tte_t               tt_wdata, tt_rdata_q, tt_ent;
  logic               tt_rvld_q;

  // control state
  logic [3:0]           state_q, state_d;
  logic [CfgW-1:0]      tc_cfg_q, tc_cfg_d;
  logic [MaxTracks-1:0] tv_q, tv_d;
  logic [CntW-1:0]      wp_q, wp_d;
  logic [TrkW-1:0]      last_q, last_d;
  logic                 playing_q, playing_d;
  logic                 out_valid_q, out_valid_d;

  // working registers
  logic [DeltaW-1:0] now_q, now_d;
  logic [TcW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]   sum_q, sum_d;
  logic [TrkW-1:0]   trk_q, trk_d;
  logic              found_q, found_d;
  logic [TrkW-1:0]   win_q, win_d;
  logic [DeltaW-1:0] best_q, best_d;
  tte_t              went_q, went_d;
  ev_t               ev0_q, ev0_d;

  // pending result and output register
  logic [1:0]        res_st_q, res_st_d;
  logic [TrkW-1:0]   res_trk_q, res_trk_d;
  logic [DeltaW-1:0] res_wait_q, res_wait_d;
  logic [1:0]        res_len_q, res_len_d;
  logic [7:0]        res_b0_q, res_b0_d, res_b1_q, res_b1_d, res_b2_q, res_b2_d;
  logic              out_load;

  logic [TcW-1:0]    tc;
  logic              in_acc;
  logic [TcW-1:0]    idx_nxt;
  logic              inuse, live, live2, load_rej;
  logic [DeltaW-1:0] pend;
  logic [CntW-1:0]   newpos;

  always_comb begin
    if (tc_cfg_q == '0) begin
      tc = TcW'(1);
    end else if (tc_cfg_q > CfgW'(MaxTracks)) begin
      tc = TcW'(MaxTracks);
    end else begin
      tc = TcW'(tc_cfg_q);
    end
  end

  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tt_ent     = tt_rvld_q ? tt_rdata_q : '0;
  assign idx_nxt    = idx_q + TcW'(1);
  assign inuse      = (idx_q < tc);
  assign live       = (tt_ent.pos < tt_ent.count);
  assign pend       = tt_ent.due - now_q;
  assign newpos     = went_q.pos + CntW'(1);
  assign live2      = (newpos < went_q.count);
  assign load_rej   = playing_q || wp_q[CntW-1] || ({1'b0, track_i} >= tc) ||
                      (track_i < last_q);
  assign out_load   = (state_q == SDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    tc_cfg_d    = tc_cfg_q;
    tv_d        = tv_q;
    wp_d        = wp_q;
    last_d      = last_q;
    playing_d   = playing_q;
    now_d       = now_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    trk_d       = trk_q;
    found_d     = found_q;
    win_d       = win_q;
    best_d      = best_q;
    went_d      = went_q;
    ev0_d       = ev0_q;
    res_st_d    = res_st_q;
    res_trk_d   = res_trk_q;
    res_wait_d  = res_wait_q;
    res_len_d   = res_len_q;
    res_b0_d    = res_b0_q;
    res_b1_d    = res_b1_q;
    res_b2_d    = res_b2_q;
    out_valid_d = out_valid_q && out_stall_i;

    ev_we    = 1'b0;
    ev_waddr = wp_q[EvAddrW-1:0];
    ev_wdata = '{delta: delta_ticks_i,
                 len: (msg_length_i == LenThree) ? LenThree : LenTwo,
                 b0: in_byte0_i, b1: in_byte1_i, b2: in_byte2_i};
    ev_raddr = '0;
    tt_we    = 1'b0;
    tt_waddr = '0;
    tt_wdata = '0;
    tt_raddr = '0;

    if (cfg_we_i && !playing_q) begin
      tc_cfg_d = cfg_wdata_i;
    end

    case (state_q)
      SIdle: begin
        tt_raddr = (cmd_i == CmdLoad) ? track_i : '0;
        if (in_acc) begin
          res_st_d   = StAck;
          res_trk_d  = '0;
          res_wait_d = '0;
          res_len_d  = '0;
          res_b0_d   = '0;
          res_b1_d   = '0;
          res_b2_d   = '0;
          case (cmd_i)
            CmdClear: begin
              tv_d      = '0;
              wp_d      = '0;
              last_d    = '0;
              playing_d = 1'b0;
              state_d   = SDone;
            end
            CmdLoad: begin
              if (load_rej) begin
                res_st_d = StRej;
                state_d  = SDone;
              end else begin
                ev_we   = 1'b1;
                wp_d    = wp_q + CntW'(1);
                last_d  = track_i;
                trk_d   = track_i;
                state_d = SLdWr;
              end
            end
            CmdStart: begin
              idx_d     = '0;
              sum_d     = '0;
              now_d     = '0;
              playing_d = 1'b1;
              state_d   = SStEv;
            end
            default: begin
              if (!playing_q) begin
                res_st_d = StRej;
                state_d  = SDone;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = SScan;
              end
            end
          endcase
        end
      end
      SLdWr: begin
        tt_we          = 1'b1;
        tt_waddr       = trk_q;
        tt_wdata       = tt_ent;
        tt_wdata.count = tt_ent.count + CntW'(1);
        tv_d[trk_q]    = 1'b1;
        state_d        = SDone;
      end
      SStEv: begin
        ev_raddr     = sum_q[EvAddrW-1:0];
        went_d       = '0;
        went_d.count = tt_ent.count;
        went_d.base  = inuse ? sum_q[EvAddrW-1:0] : '0;
        found_d      = inuse && (tt_ent.count != '0);
        if (inuse) begin
          sum_d = sum_q + tt_ent.count;
        end
        state_d = SStWr;
      end
      SStWr: begin
        tt_we        = 1'b1;
        tt_waddr     = idx_q[TrkW-1:0];
        tt_wdata     = went_q;
        tt_wdata.due = found_q ? ev_rdata_q.delta : '0;
        tv_d[idx_q[TrkW-1:0]] = 1'b1;
        tt_raddr     = idx_nxt[TrkW-1:0];
        idx_d        = idx_nxt;
        if (idx_q == TcW'(MaxTracks - 1)) begin
          state_d = SDone;
        end else begin
          state_d = SStEv;
        end
      end
      SScan: begin
        tt_raddr = idx_nxt[TrkW-1:0];
        idx_d    = idx_nxt;
        if (live && (!found_q || (pend < best_q))) begin
          found_d = 1'b1;
          win_d   = idx_q[TrkW-1:0];
          best_d  = pend;
          went_d  = tt_ent;
        end
        if (idx_nxt == tc) begin
          state_d = SEv0;
        end
      end
      SEv0: begin
        ev_raddr = went_q.base + went_q.pos[EvAddrW-1:0];
        if (!found_q) begin
          playing_d = 1'b0;
          res_st_d  = StDone;
          state_d   = SDone;
        end else begin
          state_d = SEv1;
        end
      end
      SEv1: begin
        ev0_d    = ev_rdata_q;
        ev_raddr = went_q.base + newpos[EvAddrW-1:0];
        state_d  = SEv2;
      end
      SEv2: begin
        tt_we          = 1'b1;
        tt_waddr       = win_q;
        tt_wdata       = went_q;
        tt_wdata.pos   = newpos;
        tt_wdata.due   = live2 ? (went_q.due + ev_rdata_q.delta) : went_q.due;
        tv_d[win_q]    = 1'b1;
        now_d          = went_q.due;
        res_st_d       = StEmit;
        res_trk_d      = win_q;
        res_wait_d     = best_q;
        res_len_d      = ev0_q.len;
        res_b0_d       = ev0_q.b0;
        res_b1_d       = ev0_q.b1;
        res_b2_d       = (ev0_q.len == LenThree) ? ev0_q.b2 : '0;
        state_d        = SDone;
      end
      SDone: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem[ev_waddr] <= ev_wdata;
    end
    ev_rdata_q <= ev_mem[ev_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) begin
      tt_mem[tt_waddr] <= tt_wdata;
    end
    tt_rdata_q <= tt_mem[tt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      tc_cfg_q    <= CfgW'(1);
      tv_q        <= '0;
      wp_q        <= '0;
      last_q      <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      tt_rvld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tc_cfg_q    <= tc_cfg_d;
      tv_q        <= tv_d;
      wp_q        <= wp_d;
      last_q      <= last_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
      tt_rvld_q   <= tv_q[tt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    idx_q      <= idx_d;
    sum_q      <= sum_d;
    trk_q      <= trk_d;
    found_q    <= found_d;
    win_q      <= win_d;
    best_q     <= best_d;
    went_q     <= went_d;
    ev0_q      <= ev0_d;
    res_st_q   <= res_st_d;
    res_trk_q  <= res_trk_d;
    res_wait_q <= res_wait_d;
    res_len_q  <= res_len_d;
    res_b0_q   <= res_b0_d;
    res_b1_q   <= res_b1_d;
    res_b2_q   <= res_b2_d;
    if (out_load) begin
      status_o     <= res_st_q;
      out_track_o  <= res_trk_q;
      wait_ticks_o <= res_wait_q;
      out_length_o <= res_len_q;
      out_byte0_o  <= res_b0_q;
      out_byte1_o  <= res_b1_q;
      out_byte2_o  <= res_b2_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench for the multitrack event merge scheduler: random and directed command items.
`timescale 1ns / 1ps

module tb;
  import mems_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TrkW-1:0]   trk;
    logic [DeltaW-1:0] delta;
    logic [1:0]        len;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TrkW-1:0]   trk;
    logic [DeltaW-1:0] ticks;
    logic [1:0]        len;
    logic [7:0]        b0;
    logic [7:0]        b1;
    logic [7:0]        b2;
  } merge_out_t;

  class merge_scoreboard;
    ev_t               store [EventDepth];
    logic [CntW-1:0]   evt_count [MaxTracks];
    int unsigned       base_addr [MaxTracks];
    int unsigned       play_pos [MaxTracks];
    logic [DeltaW-1:0] pend [MaxTracks];
    int unsigned       wr_ptr, last_trk, left_to_play;
    bit                playing;
    logic [CfgW-1:0]   track_count;
    merge_out_t        due_results [$];
    int                errors, n_lines, n_checked, n_emitted, n_rejected, n_done;

    function new();
      foreach (store[i]) store[i] = '0;
      clear_tracks();
      track_count = CfgW'(1);
      errors = 0;
      n_lines = 0;
      n_checked = 0;
      n_emitted = 0;
      n_rejected = 0;
      n_done = 0;
    endfunction

    function void clear_tracks();
      for (int i = 0; i < MaxTracks; i++) begin
        evt_count[i] = '0;
        base_addr[i] = 0;
        play_pos[i] = 0;
        pend[i] = '0;
      end
      wr_ptr = 0;
      last_trk = 0;
      left_to_play = 0;
      playing = 0;
    endfunction

    function int unsigned eff_tracks();
      if (track_count == 0) return 1;
      if (track_count > MaxTracks) return MaxTracks;
      return track_count;
    endfunction

    function bit is_live(int unsigned t);
      return play_pos[t] < evt_count[t];
    endfunction

    function logic [DeltaW-1:0] delta_at(int unsigned t);
      int unsigned a;
      a = base_addr[t] + play_pos[t];
      if (a >= EventDepth) return '0;
      return store[a].delta;
    endfunction

    function void write_track_count(logic [CfgW-1:0] v);
      if (!playing) track_count = v;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function merge_out_t predict_merge(cmd_item_t it);
      merge_out_t        r;
      int unsigned       tc, sum, a, win;
      bit                found;
      logic [DeltaW-1:0] best;
      r = '0;
      r.status = StAck;
      tc = eff_tracks();
      case (it.cmd)
        CmdClear: clear_tracks();
        CmdLoad: begin
          if (playing || wr_ptr >= EventDepth || it.trk >= tc || it.trk < last_trk) begin
            r.status = StRej;
          end else begin
            store[wr_ptr].delta = it.delta;
            store[wr_ptr].len = (it.len == LenThree) ? LenThree : LenTwo;
            store[wr_ptr].b0 = it.b0;
            store[wr_ptr].b1 = it.b1;
            store[wr_ptr].b2 = it.b2;
            wr_ptr++;
            evt_count[it.trk]++;
            last_trk = it.trk;
          end
        end
        CmdStart: begin
          sum = 0;
          for (int i = 0; i < MaxTracks; i++) begin
            play_pos[i] = 0;
            pend[i] = '0;
            base_addr[i] = 0;
          end
          for (int i = 0; i < tc; i++) begin
            base_addr[i] = sum;
            sum += evt_count[i];
            if (evt_count[i] != 0) pend[i] = delta_at(i);
          end
          left_to_play = sum;
          playing = 1;
        end
        default: begin
          if (!playing) begin
            r.status = StRej;
          end else begin
            found = 0;
            win = 0;
            best = '1;
            for (int i = 0; i < tc; i++) begin
              if (!is_live(i)) continue;
              if (pend[i] == 0) begin
                win = i;
                best = '0;
                found = 1;
                break;
              end
              if (!found || pend[i] < best) begin
                best = pend[i];
                win = i;
                found = 1;
              end
            end
            if (left_to_play == 0 || !found) begin
              playing = 0;
              r.status = StDone;
            end else begin
              a = base_addr[win] + play_pos[win];
              if (a < EventDepth) begin
                r.len = store[a].len;
                r.b0 = store[a].b0;
                r.b1 = store[a].b1;
                r.b2 = (store[a].len == LenThree) ? store[a].b2 : 8'h00;
              end else begin
                r.len = LenTwo;
              end
              r.status = StEmit;
              r.trk = win[TrkW-1:0];
              r.ticks = best;
              play_pos[win]++;
              pend[win] = is_live(win) ? delta_at(win) : '0;
              for (int i = 0; i < tc; i++) begin
                if (i == win || !is_live(i)) continue;
                pend[i] -= best;
              end
              left_to_play--;
            end
          end
        end
      endcase
      return r;
    endfunction

    function void note_command(cmd_item_t it);
      merge_out_t r;
      r = predict_merge(it);
      if (r.status == StEmit) n_emitted++;
      if (r.status == StRej) n_rejected++;
      if (r.status == StDone) n_done++;
      due_results.push_back(r);
    endfunction

    function void report(string field, logic [DeltaW-1:0] exp_v, logic [DeltaW-1:0] got_v);
      n_lines++;
      if (n_lines <= 60)
        $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, exp_v, got_v);
    endfunction

    function void check_result(merge_out_t got);
      merge_out_t exp_r;
      n_checked++;
      if (due_results.size() == 0) begin
        errors++;
        report("unexpected result status", '0, DeltaW'(got.status));
        return;
      end
      exp_r = due_results.pop_front();
      if (exp_r == got) return;
      errors++;
      if (exp_r.status != got.status)
        report("status", DeltaW'(exp_r.status), DeltaW'(got.status));
      if (exp_r.trk != got.trk) report("out_track", DeltaW'(exp_r.trk), DeltaW'(got.trk));
      if (exp_r.ticks != got.ticks) report("wait_ticks", exp_r.ticks, got.ticks);
      if (exp_r.len != got.len) report("out_length", DeltaW'(exp_r.len), DeltaW'(got.len));
      if (exp_r.b0 != got.b0) report("out_byte0", DeltaW'(exp_r.b0), DeltaW'(got.b0));
      if (exp_r.b1 != got.b1) report("out_byte1", DeltaW'(exp_r.b1), DeltaW'(got.b1));
      if (exp_r.b2 != got.b2) report("out_byte2", DeltaW'(exp_r.b2), DeltaW'(got.b2));
    endfunction
  endclass

  logic              clk_i, rst_ni;
  logic              cfg_we_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              in_valid_i, in_stall_o;
  logic [1:0]        cmd_i;
  logic [TrkW-1:0]   track_i;
  logic [DeltaW-1:0] delta_ticks_i;
  logic [1:0]        msg_length_i;
  logic [7:0]        in_byte0_i, in_byte1_i, in_byte2_i;
  logic              out_valid_o, out_stall_i;
  logic [1:0]        status_o;
  logic [TrkW-1:0]   out_track_o;
  logic [DeltaW-1:0] wait_ticks_o;
  logic [1:0]        out_length_o;
  logic [7:0]        out_byte0_o, out_byte1_o, out_byte2_o;

  merge_scoreboard sb;
  cmd_item_t       send_q [$];
  int              src_idle_pct, dst_idle_pct;
  bit              hold_req;
  int              items_sent;
  int              cycles;

  multitrack_event_merge_scheduler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .track_i      (track_i),
    .delta_ticks_i(delta_ticks_i),
    .msg_length_i (msg_length_i),
    .in_byte0_i   (in_byte0_i),
    .in_byte1_i   (in_byte1_i),
    .in_byte2_i   (in_byte2_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_track_o  (out_track_o),
    .wait_ticks_o (wait_ticks_o),
    .out_length_o (out_length_o),
    .out_byte0_o  (out_byte0_o),
    .out_byte1_o  (out_byte1_o),
    .out_byte2_o  (out_byte2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("%0t: timeout, %0d results still outstanding", $time, sb.outstanding());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sender: one payload update per edge, held while stalled
  initial begin
    in_valid_i <= 1'b0;
    cmd_i <= CmdClear;
    track_i <= '0;
    delta_ticks_i <= '0;
    msg_length_i <= '0;
    in_byte0_i <= '0;
    in_byte1_i <= '0;
    in_byte2_i <= '0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (in_valid_i && in_stall_o) continue;
      if (send_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        cmd_item_t it;
        it = send_q.pop_front();
        cmd_i <= it.cmd;
        track_i <= it.trk;
        delta_ticks_i <= it.delta;
        msg_length_i <= it.len;
        in_byte0_i <= it.b0;
        in_byte1_i <= it.b1;
        in_byte2_i <= it.b2;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < dst_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    cmd_item_t  acc_in;
    merge_out_t acc_out;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        acc_out.status = status_o;
        acc_out.trk = out_track_o;
        acc_out.ticks = wait_ticks_o;
        acc_out.len = out_length_o;
        acc_out.b0 = out_byte0_o;
        acc_out.b1 = out_byte1_o;
        acc_out.b2 = out_byte2_o;
        sb.check_result(acc_out);
      end
      if (in_valid_i && !in_stall_o) begin
        acc_in.cmd = cmd_i;
        acc_in.trk = track_i;
        acc_in.delta = delta_ticks_i;
        acc_in.len = msg_length_i;
        acc_in.b0 = in_byte0_i;
        acc_in.b1 = in_byte1_i;
        acc_in.b2 = in_byte2_i;
        sb.note_command(acc_in);
      end
      if (cfg_we_i) sb.write_track_count(cfg_wdata_i);
    end
  end

  function automatic logic [DeltaW-1:0] pick_delta();
    case ($urandom_range(9))
      0, 1: return '0;
      2, 3, 4, 5: return $urandom_range(1, 20);
      6: return '1;
      7: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_item_t load_item(int t, logic [DeltaW-1:0] d, logic [1:0] len,
                                          logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    cmd_item_t it;
    it.cmd = CmdLoad;
    it.trk = t[TrkW-1:0];
    it.delta = d;
    it.len = len;
    it.b0 = b0;
    it.b1 = b1;
    it.b2 = b2;
    return it;
  endfunction

  function automatic cmd_item_t random_load(int t);
    return load_item(t, pick_delta(), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  function automatic cmd_item_t plain_cmd(logic [1:0] c);
    cmd_item_t it;
    it = random_load($urandom_range(0, MaxTracks - 1));
    it.cmd = c;
    return it;
  endfunction

  task automatic push_item(cmd_item_t it);
    while (send_q.size() >= 2) @(posedge clk_i);
    send_q.push_back(it);
    items_sent++;
  endtask

  // settled check between edges, then back on a rising edge for driving
  task automatic drain();
    do @(negedge clk_i); while (send_q.size() != 0 || in_valid_i || sb.outstanding() != 0);
    @(posedge clk_i);
  endtask

  task automatic set_track_count(int v);
    drain();
    cfg_wdata_i <= v[CfgW-1:0];
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_checks();
    push_item(plain_cmd(CmdStep));
    set_track_count(3);
    push_item(load_item(0, '0, LenThree, 8'hFF, 8'h00, 8'hAA));
    push_item(load_item(0, '1, 2'd0, 8'h00, 8'hFF, 8'h55));
    push_item(load_item(2, 32'd5, 2'd1, 8'h90, 8'h3C, 8'h7F));
    push_item(load_item(1, 32'd1, LenThree, 8'h80, 8'h01, 8'h02));
    push_item(load_item(3, 32'd1, LenThree, 8'h80, 8'h01, 8'h02));
    push_item(load_item(2, 32'd5, LenTwo, 8'hC0, 8'h05, 8'hEE));
    push_item(plain_cmd(CmdStart));
    push_item(load_item(2, 32'd1, LenThree, 8'h11, 8'h22, 8'h33));
    set_track_count(1);
    repeat (5) push_item(plain_cmd(CmdStep));
    push_item(plain_cmd(CmdStep));
    push_item(plain_cmd(CmdClear));
    set_track_count(31);
    push_item(load_item(0, '1, LenThree, 8'h90, 8'h40, 8'h7F));
    push_item(load_item(5, '1, LenThree, 8'h91, 8'h41, 8'h01));
    push_item(load_item(15, '1, LenTwo, 8'hC2, 8'h10, 8'h00));
    push_item(plain_cmd(CmdStart));
    repeat (2) push_item(plain_cmd(CmdStep));
    push_item(plain_cmd(CmdStart));
    repeat (4) push_item(plain_cmd(CmdStep));
    push_item(plain_cmd(CmdClear));
    set_track_count(0);
    push_item(random_load(0));
    push_item(random_load(1));
    push_item(plain_cmd(CmdStart));
    repeat (2) push_item(plain_cmd(CmdStep));
  endtask

  task automatic random_session();
    int tc_val, eff, n, total;
    case ($urandom_range(9))
      0, 1: tc_val = $urandom_range(5, 16);
      2: tc_val = $urandom_range(0, 31);
      default: tc_val = $urandom_range(1, 4);
    endcase
    if ($urandom_range(9) != 0) push_item(plain_cmd(CmdClear));
    set_track_count(tc_val);
    eff = (tc_val == 0) ? 1 : (tc_val > MaxTracks ? MaxTracks : tc_val);
    total = 0;
    for (int t = 0; t < eff; t++) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
        push_item(random_load(t));
        total++;
        if ($urandom_range(9) == 0) push_item(random_load($urandom_range(0, MaxTracks - 1)));
      end
    end
    if ($urandom_range(9) == 0) push_item(plain_cmd(CmdStep));
    push_item(plain_cmd(CmdStart));
    if ($urandom_range(6) == 0) push_item(random_load($urandom_range(0, MaxTracks - 1)));
    n = total + 1 + $urandom_range(0, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0) push_item(plain_cmd(2'($urandom_range(0, 3))));
      push_item(plain_cmd(CmdStep));
    end
  endtask

  // with a long hold, several items are queued so that the block fills and stalls
  task automatic random_phase(int target, bit long_hold);
    if (long_hold) begin
      hold_req = 1;
      repeat (2) @(posedge clk_i);
      repeat (6) push_item(plain_cmd(CmdStep));
    end
    while (items_sent < target) random_session();
    drain();
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    hold_req = 0;
    src_idle_pct = 31;
    dst_idle_pct = 63;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    random_phase(290, 1'b1);
    src_idle_pct = 63;
    dst_idle_pct = 31;
    random_phase(550, 1'b1);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    random_phase(800, 1'b0);
    drain();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d command items and %0d results: %0d events merged, %0d rejected,",
             items_sent, sb.n_checked, sb.n_emitted, sb.n_rejected);
    $display("%0d playbacks run to the end, track counts 0..31 and restarts mid-playback.",
             sb.n_done);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
sv/mems_pkg.sv
sv/multitrack_event_merge_scheduler.sv
tb/tb.sv
